// ===== design/ltrlm_pkg.sv =====
// Shared types and constants for the link test receiver loss monitor.
package ltrlm_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_WAIT = 2'd1,
        MODE_TEST = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_START_SENT = 3'd1,
        EV_STARTED    = 3'd2,
        EV_STOP       = 3'd3,
        EV_FAILED     = 3'd4,
        EV_REPORT     = 3'd5
    } event_t;

    localparam logic [7:0] TYPE_DATA      = 8'd3;
    localparam logic [7:0] TYPE_START_ACK = 8'd4;

    localparam logic [2:0] CFG_DEBOUNCE = 3'd0;
    localparam logic [2:0] CFG_ACK_TO   = 3'd1;
    localparam logic [2:0] CFG_REPORT   = 3'd2;
    localparam logic [2:0] CFG_MAGIC    = 3'd3;
    localparam logic [2:0] CFG_VERSION  = 3'd4;
    localparam logic [2:0] CFG_BYTES    = 3'd5;

    // Classified transaction passed from the front to the back part.
    typedef struct packed {
        logic        is_tick;
        logic        frame_bad;
        logic        is_ack;
        logic        is_data;
        logic [31:0] session;
        logic [31:0] sequence_num;
        logic        button_level;
        logic [31:0] random_word;
    } cmd_t;

    // One result transaction.
    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  event_res;
        logic [31:0] session_num;
        logic [31:0] last_sequence;
        logic [31:0] received_count;
        logic [31:0] lost_count;
        logic [31:0] duplicate_count;
        logic [31:0] invalid_count;
        logic [31:0] duration_ticks;
    } result_t;

endpackage

// ===== design/ltrlm_front.sv =====
// Front part: checks frame length, magic and version and classifies the transaction.
module ltrlm_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic [7:0]         frame_length,
    input  logic [31:0]        frame_magic,
    input  logic [7:0]         frame_version,
    input  logic [7:0]         frame_type,
    input  logic [31:0]        frame_session,
    input  logic [31:0]        frame_sequence,
    input  logic               button_level,
    input  logic [31:0]        random_word,
    input  logic [31:0]        expected_magic,
    input  logic [7:0]         expected_version,
    input  logic [7:0]         frame_bytes,
    output logic               cmd_valid,
    output ltrlm_pkg::cmd_t    cmd,
    input  logic               cmd_ready
);

    logic            full_reg;
    ltrlm_pkg::cmd_t cmd_reg;
    ltrlm_pkg::cmd_t cmd_next;

    // Stage register accepts when empty or draining this cycle.
    assign in_ready  = !full_reg || cmd_ready;
    assign cmd_valid = full_reg;
    assign cmd       = cmd_reg;

    // Classify the incoming transaction.
    always_comb
    begin
        cmd_next.is_tick      = op;
        cmd_next.frame_bad    = (frame_length != frame_bytes) ||
                                (frame_magic != expected_magic) ||
                                (frame_version != expected_version);
        cmd_next.is_ack       = (frame_type == ltrlm_pkg::TYPE_START_ACK);
        cmd_next.is_data      = (frame_type == ltrlm_pkg::TYPE_DATA);
        cmd_next.session      = frame_session;
        cmd_next.sequence_num = frame_sequence;
        cmd_next.button_level = button_level;
        cmd_next.random_word  = random_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// ===== design/ltrlm_queue.sv =====
// Two-entry queue that decouples the front and back parts.
module ltrlm_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  ltrlm_pkg::cmd_t wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output ltrlm_pkg::cmd_t rd_data
);

    ltrlm_pkg::cmd_t slot_reg [2];
    logic            wptr_reg;
    logic            rptr_reg;
    logic [1:0]      count_reg;
    logic            do_wr;
    logic            do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = slot_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (do_rd)
            begin
                rptr_reg <= !rptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

// ===== design/ltrlm_back.sv =====
// Back part: session state, statistics counters and the result register.
module ltrlm_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  ltrlm_pkg::cmd_t     cmd,
    input  logic [15:0]         debounce_ticks,
    input  logic [15:0]         ack_timeout_ticks,
    input  logic [15:0]         report_interval_ticks,
    output logic                res_valid,
    input  logic                res_ready,
    output ltrlm_pkg::result_t  res
);

    ltrlm_pkg::mode_t   mode_reg, mode_next;
    logic [31:0] tick_reg, tick_next;
    logic        raw_reg, raw_next;
    logic        stable_reg, stable_next;
    logic [31:0] change_reg, change_next;
    logic [31:0] wait_reg, wait_next;
    logic [31:0] report_reg, report_next;
    logic [31:0] session_reg, session_next;
    logic [31:0] newest_reg, newest_next;
    logic [31:0] recv_reg, recv_next;
    logic [31:0] lost_reg, lost_next;
    logic [31:0] stale_reg, stale_next;
    logic [31:0] invalid_reg, invalid_next;
    logic [31:0] first_reg, first_next;
    logic [31:0] last_reg, last_next;
    logic        fseen_reg, fseen_next;
    logic        ack_reg, ack_next;
    logic        dseen_reg, dseen_next;
    logic        out_valid_reg;
    ltrlm_pkg::result_t out_reg, out_next;
    ltrlm_pkg::event_t  ev;
    logic        take;
    logic        snap_before;
    logic [31:0] now;
    logic [31:0] seq_inc;

    assign cmd_ready = !out_valid_reg || res_ready;
    assign take      = cmd_valid && cmd_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign now       = tick_reg + 32'd1;
    assign seq_inc   = newest_reg + 32'd1;

    // Next state for one transaction.
    always_comb
    begin
        mode_next    = mode_reg;
        tick_next    = tick_reg;
        raw_next     = raw_reg;
        stable_next  = stable_reg;
        change_next  = change_reg;
        wait_next    = wait_reg;
        report_next  = report_reg;
        session_next = session_reg;
        newest_next  = newest_reg;
        recv_next    = recv_reg;
        lost_next    = lost_reg;
        stale_next   = stale_reg;
        invalid_next = invalid_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        fseen_next   = fseen_reg;
        ack_next     = ack_reg;
        dseen_next   = dseen_reg;
        ev           = ltrlm_pkg::EV_NONE;
        snap_before  = 1'b0;
        if (!cmd.is_tick)
        begin
            if (cmd.frame_bad)
            begin
                invalid_next = invalid_reg + 32'd1;
            end
            else if (cmd.is_ack && cmd.session == session_reg)
            begin
                ack_next = 1'b1;
            end
            else if (cmd.is_data && mode_reg != ltrlm_pkg::MODE_IDLE &&
                     cmd.session == session_reg && cmd.sequence_num != 32'd0)
            begin
                dseen_next = 1'b1;
                if (!fseen_reg)
                begin
                    fseen_next = 1'b1;
                    first_next = tick_reg;
                end
                last_next = tick_reg;
                if (newest_reg == 32'd0 || cmd.sequence_num == seq_inc)
                begin
                    newest_next = cmd.sequence_num;
                    recv_next   = recv_reg + 32'd1;
                end
                else if (cmd.sequence_num > seq_inc)
                begin
                    lost_next   = lost_reg + (cmd.sequence_num - seq_inc);
                    newest_next = cmd.sequence_num;
                    recv_next   = recv_reg + 32'd1;
                end
                else
                begin
                    stale_next = stale_reg + 32'd1;
                end
            end
        end
        else
        begin
            tick_next = now;
            if (cmd.button_level != raw_reg)
            begin
                change_next = now;
                raw_next    = cmd.button_level;
            end
            if ((now - change_next) >= {16'd0, debounce_ticks} &&
                cmd.button_level != stable_reg)
            begin
                stable_next = cmd.button_level;
            end
            if (stable_next != stable_reg && !cmd.button_level)
            begin
                if (mode_reg != ltrlm_pkg::MODE_IDLE)
                begin
                    ev          = ltrlm_pkg::EV_STOP;
                    snap_before = 1'b1;
                    mode_next   = ltrlm_pkg::MODE_IDLE;
                end
                else
                begin
                    ev           = ltrlm_pkg::EV_START_SENT;
                    mode_next    = ltrlm_pkg::MODE_WAIT;
                    wait_next    = now;
                    report_next  = now;
                end
                newest_next  = 32'd0;
                recv_next    = 32'd0;
                lost_next    = 32'd0;
                stale_next   = 32'd0;
                invalid_next = 32'd0;
                first_next   = 32'd0;
                last_next    = 32'd0;
                fseen_next   = 1'b0;
                ack_next     = 1'b0;
                dseen_next   = 1'b0;
                if (mode_reg != ltrlm_pkg::MODE_IDLE)
                begin
                    session_next = 32'd0;
                end
                else
                begin
                    session_next = (cmd.random_word == 32'd0) ? now : cmd.random_word;
                end
            end
            else if (mode_reg == ltrlm_pkg::MODE_WAIT && (ack_reg || dseen_reg))
            begin
                ev          = ltrlm_pkg::EV_STARTED;
                mode_next   = ltrlm_pkg::MODE_TEST;
                report_next = now;
            end
            else if (mode_reg == ltrlm_pkg::MODE_WAIT &&
                     (now - wait_reg) >= {16'd0, ack_timeout_ticks})
            begin
                ev           = ltrlm_pkg::EV_FAILED;
                mode_next    = ltrlm_pkg::MODE_IDLE;
                session_next = 32'd0;
                newest_next  = 32'd0;
                recv_next    = 32'd0;
                lost_next    = 32'd0;
                stale_next   = 32'd0;
                invalid_next = 32'd0;
                first_next   = 32'd0;
                last_next    = 32'd0;
                fseen_next   = 1'b0;
                ack_next     = 1'b0;
                dseen_next   = 1'b0;
            end
            else if (mode_reg == ltrlm_pkg::MODE_TEST &&
                     (now - report_reg) >= {16'd0, report_interval_ticks})
            begin
                ev          = ltrlm_pkg::EV_REPORT;
                report_next = now;
            end
        end
    end

    // Result fields: the stop event shows the statistics before clearing.
    always_comb
    begin
        out_next.mode      = mode_next;
        out_next.event_res = ev;
        if (snap_before)
        begin
            out_next.session_num     = session_reg;
            out_next.last_sequence   = newest_reg;
            out_next.received_count  = recv_reg;
            out_next.lost_count      = lost_reg;
            out_next.duplicate_count = stale_reg;
            out_next.invalid_count   = invalid_reg;
            out_next.duration_ticks  = fseen_reg ? (last_reg - first_reg) : 32'd0;
        end
        else
        begin
            out_next.session_num     = session_next;
            out_next.last_sequence   = newest_next;
            out_next.received_count  = recv_next;
            out_next.lost_count      = lost_next;
            out_next.duplicate_count = stale_next;
            out_next.invalid_count   = invalid_next;
            out_next.duration_ticks  = fseen_next ? (last_next - first_next) : 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= ltrlm_pkg::MODE_IDLE;
            tick_reg      <= 32'd0;
            raw_reg       <= 1'b1;
            stable_reg    <= 1'b1;
            change_reg    <= 32'd0;
            wait_reg      <= 32'd0;
            report_reg    <= 32'd0;
            session_reg   <= 32'd0;
            newest_reg    <= 32'd0;
            recv_reg      <= 32'd0;
            lost_reg      <= 32'd0;
            stale_reg     <= 32'd0;
            invalid_reg   <= 32'd0;
            first_reg     <= 32'd0;
            last_reg      <= 32'd0;
            fseen_reg     <= 1'b0;
            ack_reg       <= 1'b0;
            dseen_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                mode_reg    <= mode_next;
                tick_reg    <= tick_next;
                raw_reg     <= raw_next;
                stable_reg  <= stable_next;
                change_reg  <= change_next;
                wait_reg    <= wait_next;
                report_reg  <= report_next;
                session_reg <= session_next;
                newest_reg  <= newest_next;
                recv_reg    <= recv_next;
                lost_reg    <= lost_next;
                stale_reg   <= stale_next;
                invalid_reg <= invalid_next;
                first_reg   <= first_next;
                last_reg    <= last_next;
                fseen_reg   <= fseen_next;
                ack_reg     <= ack_next;
                dseen_reg   <= dseen_next;
            end
            if (cmd_ready)
            begin
                out_valid_reg <= take;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== design/link_test_receiver_loss_monitor.sv =====
// Top level of the link test receiver loss monitor.
// Each input transaction (a received frame or a one-millisecond tick) yields exactly one
// result transaction. A front stage checks and classifies the frame, a two-entry queue
// follows, and the back part updates session state and counters and holds the
// result in an output register. One transaction is taken per clock cycle unless the output stalls;
// with no stall an accepted input passes the front register, then a queue slot, then the
// result register. Configuration is written through a plain write port; the user must write it
// only while idle, as the block itself does not enforce this.
module link_test_receiver_loss_monitor
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  frame_length,
    input  logic [31:0] frame_magic,
    input  logic [7:0]  frame_version,
    input  logic [7:0]  frame_type,
    input  logic [31:0] frame_session,
    input  logic [31:0] frame_sequence,
    input  logic        button_level,
    input  logic [31:0] random_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  mode,
    output logic [2:0]  event_res,
    output logic [31:0] session_num,
    output logic [31:0] last_sequence,
    output logic [31:0] received_count,
    output logic [31:0] lost_count,
    output logic [31:0] duplicate_count,
    output logic [31:0] invalid_count,
    output logic [31:0] duration_ticks
);

    logic [15:0] debounce_reg;
    logic [15:0] ack_to_reg;
    logic [15:0] report_int_reg;
    logic [31:0] magic_reg;
    logic [7:0]  version_reg;
    logic [7:0]  bytes_reg;

    logic               f_valid, f_ready, q_valid, q_ready;
    ltrlm_pkg::cmd_t    f_cmd, q_cmd;
    ltrlm_pkg::result_t res;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= 16'd40;
            ack_to_reg     <= 16'd2000;
            report_int_reg <= 16'd1000;
            magic_reg      <= 32'h43574E45;
            version_reg    <= 8'd1;
            bytes_reg      <= 8'd20;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ltrlm_pkg::CFG_DEBOUNCE: debounce_reg   <= cfg_data[15:0];
                ltrlm_pkg::CFG_ACK_TO:   ack_to_reg     <= cfg_data[15:0];
                ltrlm_pkg::CFG_REPORT:   report_int_reg <= cfg_data[15:0];
                ltrlm_pkg::CFG_MAGIC:    magic_reg      <= cfg_data;
                ltrlm_pkg::CFG_VERSION:  version_reg    <= cfg_data[7:0];
                ltrlm_pkg::CFG_BYTES:    bytes_reg      <= cfg_data[7:0];
                default:                 ;
            endcase
        end
    end

    ltrlm_front u_front
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .frame_length(frame_length), .frame_magic(frame_magic),
        .frame_version(frame_version), .frame_type(frame_type),
        .frame_session(frame_session), .frame_sequence(frame_sequence),
        .button_level(button_level), .random_word(random_word),
        .expected_magic(magic_reg), .expected_version(version_reg),
        .frame_bytes(bytes_reg),
        .cmd_valid(f_valid), .cmd(f_cmd), .cmd_ready(f_ready)
    );

    ltrlm_queue u_queue
    (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
    );

    ltrlm_back u_back
    (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .debounce_ticks(debounce_reg), .ack_timeout_ticks(ack_to_reg),
        .report_interval_ticks(report_int_reg),
        .res_valid(out_valid), .res_ready(out_ready), .res(res)
    );

    assign mode            = res.mode;
    assign event_res       = res.event_res;
    assign session_num     = res.session_num;
    assign last_sequence   = res.last_sequence;
    assign received_count  = res.received_count;
    assign lost_count      = res.lost_count;
    assign duplicate_count = res.duplicate_count;
    assign invalid_count   = res.invalid_count;
    assign duration_ticks  = res.duration_ticks;

    // A result stalled at the output holds its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(session_num))
        else $error("stalled result changed");

    // A stop result always shows the idle mode.
    a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == ltrlm_pkg::EV_STOP |-> mode == ltrlm_pkg::MODE_IDLE)
        else $error("stop result not idle");

    // A failed start result carries no session number and no received count.
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == ltrlm_pkg::EV_FAILED |-> session_num == 32'd0 &&
        received_count == 32'd0)
        else $error("failed start kept statistics");

endmodule
